### src/nrq_pkg.sv
package nrq_pkg;

  localparam logic [63:0] SIGN64 = 64'h8000_0000_0000_0000;
  localparam logic [63:0] MAX64  = 64'h7FFF_FFFF_FFFF_FFFF;

  localparam logic [4:0]  FRAC_BITS_RESET = 5'd31;
  localparam logic [4:0]  FRAC_BITS_MAX   = 5'd31;
  localparam logic [30:0] ONE_Q31         = 31'h7FFF_FFFF;
  localparam logic [31:0] X0_Q31          = 32'h4000_0000;
  localparam logic [31:0] X0_BASE         = 32'h2000_0000;
  // extra start shift for negative operands and operands of magnitude one or more
  localparam logic [5:0]  BIG_SHIFT       = 6'd4;

  // One beat travelling down the iteration chain.
  typedef struct packed {
    logic               valid;
    logic signed [31:0] d;
    logic [4:0]         q;
    logic [30:0]        one;
    logic [63:0]        x;
  } nrq_beat_t;

  function automatic logic [63:0] asr64(input logic [63:0] v, input logic [4:0] s);
    asr64 = 64'($signed(v) >>> s);
  endfunction

  function automatic logic [63:0] sat_sub64(input logic [63:0] a, input logic [63:0] b);
    logic [63:0] c;
    c = a - b;
    if ((a[63] ^ b[63]) && (c[63] ^ a[63])) begin
      c = a[63] ? SIGN64 : MAX64;
    end
    sat_sub64 = c;
  endfunction

  function automatic logic [63:0] sat_add64(input logic [63:0] a, input logic [63:0] b);
    logic [63:0] c;
    c = a + b;
    if (!(a[63] ^ b[63]) && (c[63] ^ a[63])) begin
      c = a[63] ? SIGN64 : MAX64;
    end
    sat_add64 = c;
  endfunction

endpackage

### src/nrq_init.sv
module nrq_init (
  input  logic                clk,
  input  logic                rst,
  input  logic                en,
  input  logic                in_valid,
  input  logic signed [31:0]  d_in,
  input  logic [4:0]          q_in,
  output nrq_pkg::nrq_beat_t  beat
);

  logic [4:0]  base;
  logic [5:0]  sh;
  logic [5:0]  sh_big;
  logic        d_small;
  logic [30:0] one_next;
  logic [31:0] x_next;

  logic               valid;
  logic signed [31:0] d;
  logic [4:0]         q;
  logic [30:0]        one;
  logic [63:0]        x;

  always_comb begin
    base     = nrq_pkg::FRAC_BITS_MAX - q_in;
    sh       = {1'b0, base};
    sh_big   = sh + nrq_pkg::BIG_SHIFT;
    d_small  = ((d_in >>> q_in) == 32'sd0);
    if (q_in == nrq_pkg::FRAC_BITS_MAX) begin
      one_next = nrq_pkg::ONE_Q31;
      x_next   = nrq_pkg::X0_Q31;
    end else begin
      one_next = nrq_pkg::ONE_Q31 >> base;
      x_next   = d_small ? (nrq_pkg::X0_BASE >> sh) : (nrq_pkg::X0_BASE >> sh_big);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (en) begin
      valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      d   <= d_in;
      q   <= q_in;
      one <= one_next;
      x   <= {32'b0, x_next};
    end
  end

  assign beat = '{valid: valid, d: d, q: q, one: one, x: x};

endmodule

### src/nrq_cell.sv
// One Newton step in four stages:
// partials of d*x, sum/shift/sat-sub, partials of x*diff, sum/shift/sat-add.
module nrq_cell (
  input  logic               clk,
  input  logic               rst,
  input  logic               en,
  input  nrq_pkg::nrq_beat_t in_beat,
  output nrq_pkg::nrq_beat_t out_beat
);

  // sign extension of d as the upper word
  logic [31:0] d_hi;
  assign d_hi = in_beat.d[31] ? 32'hFFFF_FFFF : 32'h0;

  // stage A
  logic               a_valid;
  logic signed [31:0] a_d;
  logic [4:0]         a_q;
  logic [30:0]        a_one;
  logic [63:0]        a_x;
  logic [63:0]        a_p0;
  logic [31:0]        a_p1;
  logic [31:0]        a_p2;

  // stage B
  logic               b_valid;
  logic signed [31:0] b_d;
  logic [4:0]         b_q;
  logic [30:0]        b_one;
  logic [63:0]        b_x;
  logic [63:0]        b_diff;

  // stage C
  logic               c_valid;
  logic signed [31:0] c_d;
  logic [4:0]         c_q;
  logic [30:0]        c_one;
  logic [63:0]        c_x;
  logic [63:0]        c_p0;
  logic [31:0]        c_p1;
  logic [31:0]        c_p2;

  // stage D
  logic               o_valid;
  logic signed [31:0] o_d;
  logic [4:0]         o_q;
  logic [30:0]        o_one;
  logic [63:0]        o_x;

  logic [63:0] a_prod;
  logic [63:0] b_diff_next;
  logic [63:0] c_prod;
  logic [63:0] o_x_next;

  // low 64 bits of a 64x64 product from three 32x32 partials
  always_comb begin
    a_prod      = a_p0 + {a_p1 + a_p2, 32'b0};
    b_diff_next = nrq_pkg::sat_sub64({33'b0, a_one}, nrq_pkg::asr64(a_prod, a_q));
    c_prod      = c_p0 + {c_p1 + c_p2, 32'b0};
    o_x_next    = nrq_pkg::sat_add64(c_x, nrq_pkg::asr64(c_prod, c_q));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
      b_valid <= 1'b0;
      c_valid <= 1'b0;
      o_valid <= 1'b0;
    end else if (en) begin
      a_valid <= in_beat.valid;
      b_valid <= a_valid;
      c_valid <= b_valid;
      o_valid <= c_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      a_d   <= in_beat.d;
      a_q   <= in_beat.q;
      a_one <= in_beat.one;
      a_x   <= in_beat.x;
      a_p0  <= in_beat.x[31:0] * in_beat.d[31:0];
      a_p1  <= in_beat.x[63:32] * in_beat.d[31:0];
      a_p2  <= in_beat.x[31:0] * d_hi;

      b_d    <= a_d;
      b_q    <= a_q;
      b_one  <= a_one;
      b_x    <= a_x;
      b_diff <= b_diff_next;

      c_d   <= b_d;
      c_q   <= b_q;
      c_one <= b_one;
      c_x   <= b_x;
      c_p0  <= b_x[31:0] * b_diff[31:0];
      c_p1  <= b_x[63:32] * b_diff[31:0];
      c_p2  <= b_x[31:0] * b_diff[63:32];

      o_d   <= c_d;
      o_q   <= c_q;
      o_one <= c_one;
      o_x   <= o_x_next;
    end
  end

  assign out_beat = '{valid: o_valid, d: o_d, q: o_q, one: o_one, x: o_x};

endmodule

### src/newton_reciprocal_qformat.sv
// From accept to output a beat passes one start stage, four stages per Newton
// cell and the output register.
// Throughput: one beat per cycle; the chain stalls only while the output skid
// register is full.
// Reset: clears all valid flags and sets frac_bits to 31; no clearing pass.
module newton_reciprocal_qformat #(
  parameter int ITERATIONS = 20
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_wr_en,
  input  logic [4:0]         cfg_wr_data,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic signed [31:0] denominator,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [31:0] reciprocal
);

  logic [4:0] frac_bits;
  logic       en;
  logic       take;

  logic               skid_valid;
  logic signed [31:0] skid_data;

  nrq_pkg::nrq_beat_t chain [0:ITERATIONS];
  nrq_pkg::nrq_beat_t tail;

  always_ff @(posedge clk) begin
    if (rst) begin
      frac_bits <= nrq_pkg::FRAC_BITS_RESET;
    end else if (cfg_wr_en) begin
      frac_bits <= cfg_wr_data;
    end
  end

  assign en       = !skid_valid;
  assign in_ready = en;
  assign take     = out_valid && out_ready;

  nrq_init u_init (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .in_valid (in_valid),
    .d_in     (denominator),
    .q_in     (frac_bits),
    .beat     (chain[0])
  );

  for (genvar i = 0; i < ITERATIONS; i++) begin : g_cell
    nrq_cell u_cell (
      .clk      (clk),
      .rst      (rst),
      .en       (en),
      .in_beat  (chain[i]),
      .out_beat (chain[i+1])
    );
  end

  assign tail = chain[ITERATIONS];

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (skid_valid) begin
      if (take) begin
        skid_valid <= 1'b0;
      end
    end else if (tail.valid) begin
      if (!out_valid || take) begin
        out_valid <= 1'b1;
      end else begin
        skid_valid <= 1'b1;
      end
    end else if (take) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (skid_valid) begin
      if (take) begin
        reciprocal <= skid_data;
      end
    end else if (tail.valid) begin
      if (!out_valid || take) begin
        reciprocal <= tail.x[31:0];
      end else begin
        skid_data <= tail.x[31:0];
      end
    end
  end

endmodule

### tb/newton_reciprocal_qformat_tb.sv
`timescale 1ns / 1ps

module newton_reciprocal_qformat_tb;

  localparam int NEWTON_STEPS = 20;
  localparam int PIPE_LATENCY = 4 * NEWTON_STEPS + 2;
  localparam int CYCLE_LIMIT  = 400000;

  localparam logic signed [63:0] SAT_MAX = 64'sh7FFF_FFFF_FFFF_FFFF;
  localparam logic signed [63:0] SAT_MIN = 64'sh8000_0000_0000_0000;

  typedef struct {
    logic signed [31:0] den;
    logic [4:0]         frac;
    logic [31:0]        recip;
  } recip_check_t;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               cfg_wr_en = 1'b0;
  logic [4:0]         cfg_wr_data = '0;
  logic               in_valid = 1'b0;
  logic               in_ready;
  logic signed [31:0] denominator = '0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  logic signed [31:0] reciprocal;

  recip_check_t pending_recips[$];
  logic [4:0]   cur_frac = nrq_pkg::FRAC_BITS_RESET;
  int           cycle_count = 0;
  int           error_count = 0;
  int           items_sent = 0;
  int           results_checked = 0;
  int           formats_written = 0;
  bit           send_burst = 1'b0;
  bit           sink_burst = 1'b0;
  int unsigned  sink_hold = 0;

  newton_reciprocal_qformat #(
    .ITERATIONS(NEWTON_STEPS)
  ) uut (
    .clk(clk),
    .rst(rst),
    .cfg_wr_en(cfg_wr_en),
    .cfg_wr_data(cfg_wr_data),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .denominator(denominator),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .reciprocal(reciprocal)
  );

  always #6 clk = ~clk;

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles, %0d results outstanding",
               cycle_count, pending_recips.size());
      $display("Regression FAIL");
      $finish;
    end
  end

  // Newton iteration on 64-bit wrapping products, saturating add/sub.
  function automatic logic [31:0] predict_reciprocal(input logic signed [31:0] den,
                                                     input logic [4:0] q);
    logic signed [63:0] d, x, one, prod, diff, sum;
    int unsigned base;
    int i;
    d = den;
    if (q == 5'd31) begin
      x = 64'sh4000_0000;
      one = 64'sh7FFF_FFFF;
    end else begin
      base = 31 - q;
      one = 64'sh7FFF_FFFF >> base;
      // denominators of magnitude one or more (and all negatives) start smaller
      if ((d >>> q) == 64'sd0) x = 64'sh2000_0000 >> base;
      else x = 64'sh2000_0000 >> (base + 4);
    end
    for (i = 0; i < NEWTON_STEPS; i++) begin
      prod = (d * x) >>> q;
      diff = one - prod;
      if ((one[63] != prod[63]) && (diff[63] != one[63])) begin
        diff = one[63] ? SAT_MIN : SAT_MAX;
      end
      prod = (x * diff) >>> q;
      sum = x + prod;
      if ((x[63] == prod[63]) && (sum[63] != x[63])) begin
        sum = x[63] ? SAT_MIN : SAT_MAX;
      end
      x = sum;
    end
    return x[31:0];
  endfunction

  function automatic logic signed [31:0] pick_denominator(input logic [4:0] q);
    logic [31:0] unit;
    logic [31:0] v;
    unit = 32'(64'd1 << q);
    case ($urandom_range(0, 5))
      0: v = $urandom;
      1: v = unit + 32'($urandom_range(0, 2047)) - 32'd1024;
      2: v = $urandom >> $urandom_range(0, 31);
      3: v = -($urandom >> $urandom_range(0, 31));
      4: begin
        case ($urandom_range(0, 5))
          0: v = 32'h0000_0000;
          1: v = 32'h0000_0001;
          2: v = 32'hFFFF_FFFF;
          3: v = 32'h7FFF_FFFF;
          4: v = 32'h8000_0000;
          default: v = unit;
        endcase
      end
      default: v = (unit << $urandom_range(0, 3)) ^ ($urandom & 32'hFF);
    endcase
    return v;
  endfunction

  task automatic report_mismatch(input string what);
    error_count++;
    $display("MISMATCH cycle %0d: %s", cycle_count, what);
  endtask

  // Result side: ready may drop after each beat, unless the sink is in burst mode.
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
      sink_hold = 0;
    end else if (out_ready && out_valid) begin
      sink_hold = sink_burst ? 0 : $urandom_range(0, 19);
      if (sink_hold != 0) out_ready <= 1'b0;
      if ($urandom_range(0, 24) == 0) sink_burst = !sink_burst;
    end else if (!out_ready) begin
      if (sink_hold > 0) sink_hold = sink_hold - 1;
      if (sink_hold == 0) out_ready <= 1'b1;
    end
  end

  always @(posedge clk) begin : check_results
    recip_check_t want;
    if (!rst && out_valid && out_ready) begin
      if (pending_recips.size() == 0) begin
        report_mismatch($sformatf("unexpected reciprocal %h", reciprocal));
      end else begin
        want = pending_recips.pop_front();
        results_checked++;
        if (reciprocal !== want.recip) begin
          report_mismatch($sformatf("d=%h q=%0d: reciprocal %h, want %h",
                                    want.den, want.frac, reciprocal, want.recip));
        end
      end
    end
  end

  task automatic send_denominator(input logic signed [31:0] den);
    int unsigned gap;
    gap = send_burst ? 0 : $urandom_range(0, 19);
    if ($urandom_range(0, 19) == 0) send_burst = !send_burst;
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    denominator <= den;
    do begin
      @(posedge clk);
    end while (!in_ready);
    pending_recips.push_back('{den, cur_frac, predict_reciprocal(den, cur_frac)});
    items_sent++;
  endtask

  task automatic wait_for_results();
    in_valid <= 1'b0;
    while (pending_recips.size() != 0) @(posedge clk);
  endtask

  // only called with the pipe empty
  task automatic set_frac_bits(input logic [4:0] q);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= q;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    cur_frac = q;
    formats_written++;
  endtask

  task automatic test_reset_format();
    send_denominator(32'sh0000_0000);
    send_denominator(32'sh0000_0001);
    send_denominator(-32'sd1);
    send_denominator(32'sh7FFF_FFFF);
    send_denominator(32'sh8000_0000);
    send_denominator(32'sh4000_0000);
    send_denominator(32'sh6000_0000);
    wait_for_results();
  endtask

  task automatic test_format_extremes();
    // q = 0: start estimate shifts out to zero
    set_frac_bits(5'd0);
    send_denominator(32'sd1);
    send_denominator(32'sd2);
    send_denominator(32'sd0);
    send_denominator(-32'sd1);
    wait_for_results();
    set_frac_bits(5'd16);
    send_denominator(32'sh0001_0000);
    send_denominator(32'sh0000_8000);
    send_denominator(32'sh0003_0000);
    send_denominator(-32'sh0002_0000);
    send_denominator(32'sh7FFF_FFFF);
    wait_for_results();
    set_frac_bits(5'd30);
    send_denominator(32'sh4000_0000);
    send_denominator(32'sh2000_0000);
    send_denominator(32'sh8000_0000);
    wait_for_results();
    set_frac_bits(5'd1);
    send_denominator(32'sd3);
    wait_for_results();
    set_frac_bits(5'd31);
    send_denominator(32'sh7FFF_FFFF);
    wait_for_results();
  endtask

  task automatic test_random_formats();
    logic [4:0] formats[10];
    int p, n;
    formats = '{5'd31, 5'd0, 5'd15, 5'd8, 5'd24, 5'd30, 5'd1, 5'd0, 5'd0, 5'd16};
    formats[7] = 5'($urandom_range(0, 31));
    formats[8] = 5'($urandom_range(0, 31));
    for (p = 0; p < 10; p++) begin
      set_frac_bits(formats[p]);
      for (n = 0; n < 40; n++) begin
        // hold off mid-phase until the pipe has drained
        if (n == 20 && p % 2 == 0) wait_for_results();
        send_denominator(pick_denominator(cur_frac));
      end
      wait_for_results();
    end
  endtask

  initial begin
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_reset_format();
    test_format_extremes();
    test_random_formats();
    repeat (PIPE_LATENCY + 16) @(posedge clk);
    if (pending_recips.size() != 0) begin
      report_mismatch($sformatf("%0d reciprocals never arrived", pending_recips.size()));
    end
    $display("Sent %0d denominators across %0d fraction-bit writes plus the reset format",
             items_sent, formats_written);
    $display("Checked %0d reciprocals, %0d mismatches", results_checked, error_count);
    if (error_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
